/* sv/brb_pkg.sv */
`timescale 1ns / 1ps

package brb_pkg;

	localparam int STORE_DEPTH    = 4096;
	localparam int MAX_READ_BURST = 64;

	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int RD_W  = $clog2(MAX_READ_BURST + 1);

	localparam logic [2:0] CMD_RESERVE = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_READ    = 3'd2;
	localparam logic [2:0] CMD_REWIND  = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_REJECT = 2'd1;
	localparam logic [1:0] STATUS_NONE   = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic read_step;
		logic rewind_apply;
	} brb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rd_none;
		logic rd_last;
	} brb_stat_t;

endpackage

/* sv/byte_ring_buffer_with_rewind.sv */
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// command   in         start, busy             cmd, data_byte, count
// result    out        strobe (one cycle)      status, read_byte, last, amount, fill_level
// config    in         cfg_we                  cfg_data (capacity_in_use)
//
// reserve, write byte and clear: result registered, shown in the cycle after the transfer;
//   next command may follow in the very next cycle
// rewind: busy while it is applied in its own state; read of n bytes: busy through the
//   read steps, one byte per cycle off the single read port of the byte store
// reset clears pointers, fill, burst state and sets capacity to the full store;
//   the store itself is not cleared, only written bytes are ever read
// the receiver cannot stall: every result is shown for exactly one cycle

module byte_ring_buffer_with_rewind (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                cmd,
	input  logic [7:0]                data_byte,
	input  logic [brb_pkg::CNT_W-1:0] count,
	input  logic                      cfg_we,
	input  logic [brb_pkg::CNT_W-1:0] cfg_data,
	output logic                      strobe,
	output logic [1:0]                status,
	output logic [7:0]                read_byte,
	output logic                      last,
	output logic [brb_pkg::CNT_W-1:0] amount,
	output logic [brb_pkg::CNT_W-1:0] fill_level
);

	// command and status between sequencer and datapath
	brb_pkg::brb_cmd_t  ctl;
	brb_pkg::brb_stat_t stat;

	// sequencer: idle, read burst, rewind apply
	brb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// pointers, fill count, burst bookkeeping, byte store and result registers
	brb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.count      (count),
		.ctl        (ctl),
		.stat       (stat),
		.strobe     (strobe),
		.status     (status),
		.read_byte  (read_byte),
		.last       (last),
		.amount     (amount),
		.fill_level (fill_level)
	);

	// a result that is not the last of its command comes only from a read burst
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result outside a read burst");

	// the ring never holds more than the store
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> fill_level <= brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH))
		else $error("fill level above store depth");

	// an empty or rejected result carries no byte and no amount
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != brb_pkg::STATUS_OK |-> read_byte == 8'd0 && amount == '0 && last)
		else $error("failed result carries data");

	// during a read burst each transfer drops the fill level by one
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && fill_level == $past(fill_level) - brb_pkg::CNT_W'(1))
		else $error("read burst fill level out of step");

endmodule

/* sv/brb_ctrl.sv */
`timescale 1ns / 1ps

module brb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [2:0]        cmd,
	input  brb_pkg::brb_stat_t stat,
	output logic              busy,
	output brb_pkg::brb_cmd_t ctl
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_REWIND = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d          = state_q;
		ctl.accept       = 1'b0;
		ctl.read_step    = 1'b0;
		ctl.rewind_apply = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					if (cmd == brb_pkg::CMD_READ && !stat.rd_none) begin
						state_d = ST_READ;
					end else if (cmd == brb_pkg::CMD_REWIND) begin
						state_d = ST_REWIND;
					end
				end
			end
			ST_READ: begin
				ctl.read_step = 1'b1;
				if (stat.rd_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_REWIND: begin
				ctl.rewind_apply = 1'b1;
				state_d          = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/brb_dp.sv */
`timescale 1ns / 1ps

module brb_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [brb_pkg::CNT_W-1:0] cfg_data,
	input  logic [2:0]                cmd,
	input  logic [7:0]                data_byte,
	input  logic [brb_pkg::CNT_W-1:0] count,
	input  brb_pkg::brb_cmd_t         ctl,
	output brb_pkg::brb_stat_t        stat,
	output logic                      strobe,
	output logic [1:0]                status,
	output logic [7:0]                read_byte,
	output logic                      last,
	output logic [brb_pkg::CNT_W-1:0] amount,
	output logic [brb_pkg::CNT_W-1:0] fill_level
);

	logic [7:0] mem [brb_pkg::STORE_DEPTH];

	logic [brb_pkg::IDX_W-1:0] head_q;
	logic [brb_pkg::IDX_W-1:0] tail_q;
	logic [brb_pkg::CNT_W-1:0] held_q;
	logic [brb_pkg::CNT_W-1:0] cap_q;
	logic [brb_pkg::CNT_W-1:0] burst_rem_q;
	logic                      burst_rej_q;
	logic [brb_pkg::RD_W-1:0]  rd_left_q;
	logic [brb_pkg::RD_W-1:0]  rd_cnt_q;
	logic [brb_pkg::CNT_W-1:0] rw_n_q;

	logic                      strobe_q;
	logic [1:0]                status_q;
	logic                      last_q;
	logic [brb_pkg::CNT_W-1:0] amount_q;
	logic [brb_pkg::CNT_W-1:0] fill_q;
	logic                      byte_sel_q;
	logic [7:0]                rd_data_q;

	logic [brb_pkg::CNT_W-1:0] rd_cap;
	logic [brb_pkg::CNT_W-1:0] rd_n;
	logic [brb_pkg::CNT_W-1:0] rw_n;
	logic [brb_pkg::CNT_W-1:0] cap_clamped;
	logic [brb_pkg::CNT_W-1:0] tail_inc;
	logic [brb_pkg::CNT_W-1:0] head_inc;
	logic [brb_pkg::CNT_W:0]   resv_sum;
	logic                      resv_over;
	logic                      wr_ok;
	logic                      wr_en;

	logic                      res_valid;
	logic [1:0]                res_status;
	logic                      res_last;
	logic [brb_pkg::CNT_W-1:0] res_amount;
	logic [brb_pkg::CNT_W-1:0] res_fill;
	logic                      res_byte_sel;

	// read length: min of count, burst limit and fill
	assign rd_cap = (count > brb_pkg::CNT_W'(brb_pkg::MAX_READ_BURST)) ?
		brb_pkg::CNT_W'(brb_pkg::MAX_READ_BURST) : count;
	assign rd_n   = (rd_cap > held_q) ? held_q : rd_cap;
	assign rw_n   = (count > held_q) ? held_q : count;

	assign stat.rd_none = (rd_n == '0);
	assign stat.rd_last = (rd_left_q == brb_pkg::RD_W'(1));

	assign cap_clamped = (cfg_data == '0) ? brb_pkg::CNT_W'(1) :
		((cfg_data > brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH)) ?
		brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH) : cfg_data);

	assign tail_inc  = brb_pkg::CNT_W'(tail_q) + brb_pkg::CNT_W'(1);
	assign head_inc  = brb_pkg::CNT_W'(head_q) + brb_pkg::CNT_W'(1);
	assign resv_sum  = {1'b0, held_q} + {1'b0, count};
	assign resv_over = (resv_sum > {1'b0, cap_q});
	assign wr_ok     = (burst_rem_q != '0) && !burst_rej_q;
	assign wr_en     = ctl.accept && (cmd == brb_pkg::CMD_WRITE) && wr_ok;

	// result of this cycle, registered to the ports
	always_comb begin
		res_valid    = 1'b0;
		res_status   = brb_pkg::STATUS_OK;
		res_last     = 1'b1;
		res_amount   = '0;
		res_fill     = held_q;
		res_byte_sel = 1'b0;
		if (ctl.accept) begin
			case (cmd)
				brb_pkg::CMD_RESERVE: begin
					res_valid = 1'b1;
					if (resv_over) begin
						res_status = brb_pkg::STATUS_REJECT;
					end else begin
						res_amount = count;
					end
				end
				brb_pkg::CMD_WRITE: begin
					res_valid = 1'b1;
					if (wr_ok) begin
						res_amount = brb_pkg::CNT_W'(1);
						res_fill   = held_q + brb_pkg::CNT_W'(1);
					end else begin
						res_status = brb_pkg::STATUS_REJECT;
					end
				end
				brb_pkg::CMD_READ: begin
					if (stat.rd_none) begin
						res_valid  = 1'b1;
						res_status = brb_pkg::STATUS_NONE;
					end
				end
				brb_pkg::CMD_CLEAR: begin
					res_valid = 1'b1;
					res_fill  = '0;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
		if (ctl.read_step) begin
			res_valid    = 1'b1;
			res_byte_sel = 1'b1;
			res_last     = stat.rd_last;
			res_amount   = brb_pkg::CNT_W'(rd_cnt_q) + brb_pkg::CNT_W'(1);
			res_fill     = held_q - brb_pkg::CNT_W'(1);
		end
		if (ctl.rewind_apply) begin
			res_valid = 1'b1;
			if (rw_n_q == '0) begin
				res_status = brb_pkg::STATUS_NONE;
			end else begin
				res_amount = rw_n_q;
				res_fill   = held_q - rw_n_q;
			end
		end
	end

	// byte store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= data_byte;
		end
		if (ctl.read_step) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			cap_q       <= brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH);
			burst_rem_q <= '0;
			burst_rej_q <= 1'b0;
			rd_left_q   <= '0;
			rd_cnt_q    <= '0;
			rw_n_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= res_valid;
			if (cfg_we) begin
				cap_q       <= cap_clamped;
				head_q      <= '0;
				tail_q      <= '0;
				held_q      <= '0;
				burst_rem_q <= '0;
				burst_rej_q <= 1'b0;
			end else if (ctl.accept) begin
				case (cmd)
					brb_pkg::CMD_RESERVE: begin
						burst_rem_q <= count;
						burst_rej_q <= resv_over;
					end
					brb_pkg::CMD_WRITE: begin
						if (wr_ok) begin
							burst_rem_q <= burst_rem_q - brb_pkg::CNT_W'(1);
							tail_q      <= (tail_inc >= cap_q) ? '0 :
								tail_inc[brb_pkg::IDX_W-1:0];
							held_q      <= held_q + brb_pkg::CNT_W'(1);
						end else if (burst_rem_q != '0) begin
							// rejected burst: count its bytes off
							burst_rem_q <= burst_rem_q - brb_pkg::CNT_W'(1);
							if (burst_rem_q == brb_pkg::CNT_W'(1)) begin
								burst_rej_q <= 1'b0;
							end
						end
					end
					brb_pkg::CMD_READ: begin
						rd_left_q <= rd_n[brb_pkg::RD_W-1:0];
						rd_cnt_q  <= '0;
					end
					brb_pkg::CMD_REWIND: begin
						rw_n_q <= rw_n;
					end
					brb_pkg::CMD_CLEAR: begin
						head_q      <= '0;
						tail_q      <= '0;
						held_q      <= '0;
						burst_rem_q <= '0;
						burst_rej_q <= 1'b0;
					end
					default: begin
						rw_n_q <= rw_n_q;
					end
				endcase
			end else if (ctl.read_step) begin
				head_q    <= (head_inc >= cap_q) ? '0 : head_inc[brb_pkg::IDX_W-1:0];
				held_q    <= held_q - brb_pkg::CNT_W'(1);
				rd_left_q <= rd_left_q - brb_pkg::RD_W'(1);
				rd_cnt_q  <= rd_cnt_q + brb_pkg::RD_W'(1);
			end else if (ctl.rewind_apply) begin
				if (rw_n_q != '0) begin
					held_q <= held_q - rw_n_q;
					if (brb_pkg::CNT_W'(tail_q) < rw_n_q) begin
						tail_q <= brb_pkg::IDX_W'(cap_q - (rw_n_q - brb_pkg::CNT_W'(tail_q)));
					end else begin
						tail_q <= brb_pkg::IDX_W'(brb_pkg::CNT_W'(tail_q) - rw_n_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q   <= res_status;
			last_q     <= res_last;
			amount_q   <= res_amount;
			fill_q     <= res_fill;
			byte_sel_q <= res_byte_sel;
		end
	end

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign last       = last_q;
	assign amount     = amount_q;
	assign fill_level = fill_q;
	assign read_byte  = byte_sel_q ? rd_data_q : 8'd0;

endmodule

/* verif/byte_ring_buffer_with_rewind_tb.sv */
`timescale 1ns / 1ps

module byte_ring_buffer_with_rewind_tb;

	// codes the block has no meaning for: taken, but never answered
	localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;

	// cycles with no transfer of any kind before the run is called dead
	localparam int QUIET_LIMIT = 3000;
	// settle time once the last expected result is in
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [2:0]                op;
		logic [7:0]                din;
		logic [brb_pkg::CNT_W-1:0] n_req;
	} ring_cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [7:0]                rd;
		logic                      last;
		logic [brb_pkg::CNT_W-1:0] amount;
		logic [brb_pkg::CNT_W-1:0] fill;
	} ring_result_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      start      = 1'b0;
	logic                      busy;
	logic [2:0]                cmd        = brb_pkg::CMD_RESERVE;
	logic [7:0]                data_byte  = '0;
	logic [brb_pkg::CNT_W-1:0] count      = '0;
	logic                      cfg_we     = 1'b0;
	logic [brb_pkg::CNT_W-1:0] cfg_data   = '0;
	logic                      strobe;
	logic [1:0]                status;
	logic [7:0]                read_byte;
	logic                      last;
	logic [brb_pkg::CNT_W-1:0] amount;
	logic [brb_pkg::CNT_W-1:0] fill_level;

	byte_ring_buffer_with_rewind DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.count      (count),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.status     (status),
		.read_byte  (read_byte),
		.last       (last),
		.amount     (amount),
		.fill_level (fill_level)
	);

	// 4 ns period, high then low
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// commands waiting to go out, results the ring still owes us
	ring_cmd_t    commands_to_send[$];
	ring_result_t results_due[$];

	// shadow ring: store, pointers, fill, burst bookkeeping, capacity register
	logic [7:0]                ring_bytes[brb_pkg::STORE_DEPTH];
	int                        head_pos     = 0;
	int                        tail_pos     = 0;
	int                        held         = 0;
	int                        burst_left   = 0;
	bit                        burst_bad    = 1'b0;
	logic [brb_pkg::CNT_W-1:0] capacity_reg = brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH);

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int cmds_issued    = 0;
	int cmds_taken     = 0;
	int idle_pct       = 20;
	int gap_left       = 0;

	ring_cmd_t    next_cmd;
	ring_result_t got;
	ring_result_t want;

	function automatic void empty_ring_model();
		head_pos   = 0;
		tail_pos   = 0;
		held       = 0;
		burst_left = 0;
		burst_bad  = 1'b0;
	endfunction

	// advance the shadow ring by one command and queue what it must answer
	task automatic apply_ring_command(input logic [2:0] op, input logic [7:0] din,
			input logic [brb_pkg::CNT_W-1:0] n_req);
		int lim;
		int n;
		ring_result_t r;
		// capacity register is clamped into 1..store depth
		lim = (capacity_reg == 0) ? 1 :
			(int'(capacity_reg) > brb_pkg::STORE_DEPTH) ? brb_pkg::STORE_DEPTH :
			int'(capacity_reg);
		r = '0;
		r.last = 1'b1;
		case (op)
			brb_pkg::CMD_RESERVE: begin
				// a new booking drops whatever is left of the old one
				burst_left = int'(n_req);
				if (held + int'(n_req) > lim) begin
					burst_bad = 1'b1;
					r.status = brb_pkg::STATUS_REJECT;
				end else begin
					burst_bad = 1'b0;
					r.status = brb_pkg::STATUS_OK;
					r.amount = n_req;
				end
				r.fill = brb_pkg::CNT_W'(held);
				results_due.push_back(r);
			end
			brb_pkg::CMD_WRITE: begin
				if (burst_left == 0 || burst_bad) begin
					// dropped: no booking, or the booking was refused
					if (burst_left != 0) begin
						burst_left--;
						if (burst_left == 0)
							burst_bad = 1'b0;
					end
					r.status = brb_pkg::STATUS_REJECT;
				end else begin
					burst_left--;
					ring_bytes[tail_pos] = din;
					tail_pos = (tail_pos + 1 >= lim) ? 0 : tail_pos + 1;
					held++;
					r.status = brb_pkg::STATUS_OK;
					r.amount = 1;
				end
				r.fill = brb_pkg::CNT_W'(held);
				results_due.push_back(r);
			end
			brb_pkg::CMD_READ: begin
				n = int'(n_req);
				if (n > brb_pkg::MAX_READ_BURST)
					n = brb_pkg::MAX_READ_BURST;
				if (n > held)
					n = held;
				if (n == 0) begin
					r.status = brb_pkg::STATUS_NONE;
					r.fill = brb_pkg::CNT_W'(held);
					results_due.push_back(r);
				end else begin
					for (int k = 0; k < n; k++) begin
						r.status = brb_pkg::STATUS_OK;
						r.rd = ring_bytes[head_pos];
						head_pos = (head_pos + 1 >= lim) ? 0 : head_pos + 1;
						held--;
						r.last = (k + 1 == n);
						r.amount = brb_pkg::CNT_W'(k + 1);
						r.fill = brb_pkg::CNT_W'(held);
						results_due.push_back(r);
					end
				end
			end
			brb_pkg::CMD_REWIND: begin
				n = (int'(n_req) < held) ? int'(n_req) : held;
				if (n == 0) begin
					r.status = brb_pkg::STATUS_NONE;
				end else begin
					// pull the tail back, wrapping below zero
					held -= n;
					if (tail_pos < n)
						tail_pos = lim - (n - tail_pos);
					else
						tail_pos -= n;
					r.status = brb_pkg::STATUS_OK;
					r.amount = brb_pkg::CNT_W'(n);
				end
				r.fill = brb_pkg::CNT_W'(held);
				results_due.push_back(r);
			end
			brb_pkg::CMD_CLEAR: begin
				empty_ring_model();
				r.status = brb_pkg::STATUS_OK;
				results_due.push_back(r);
			end
			default: begin
				// undefined codes leave the ring alone and answer nothing
			end
		endcase
	endtask

	task automatic queue_cmd(input logic [2:0] op, input logic [7:0] din,
			input logic [brb_pkg::CNT_W-1:0] n_req);
		ring_cmd_t c;
		c.op    = op;
		c.din   = din;
		c.n_req = n_req;
		commands_to_send.push_back(c);
	endtask

	// mostly well-formed bookings followed by their bytes, mixed with reads,
	// rewinds, clears and a share of junk
	task automatic queue_random_traffic(input int target);
		int queued;
		int pick;
		int len;
		int sent;
		queued = 0;
		while (queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) :
					$urandom_range(1, 8);
				// now and then the burst is cut short and left dangling
				sent = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
				queue_cmd(brb_pkg::CMD_RESERVE, 8'($urandom_range(0, 255)),
					brb_pkg::CNT_W'(len));
				for (int k = 0; k < sent; k++)
					queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom_range(0, 255)),
						brb_pkg::CNT_W'($urandom));
				queued += sent + 1;
			end else begin
				if (pick < 72)
					queue_cmd(brb_pkg::CMD_READ, 8'($urandom),
						($urandom_range(0, 5) == 0) ? brb_pkg::CNT_W'($urandom) :
						brb_pkg::CNT_W'($urandom_range(0, 70)));
				else if (pick < 82)
					queue_cmd(brb_pkg::CMD_REWIND, 8'($urandom),
						($urandom_range(0, 4) == 0) ? brb_pkg::CNT_W'($urandom) :
						brb_pkg::CNT_W'($urandom_range(0, 10)));
				else if (pick < 85)
					queue_cmd(brb_pkg::CMD_CLEAR, 8'($urandom), brb_pkg::CNT_W'($urandom));
				else if (pick < 91)
					// stray byte with no booking behind it, or trailing a refused one
					queue_cmd(brb_pkg::CMD_WRITE, 8'($urandom), brb_pkg::CNT_W'($urandom));
				else if (pick < 97)
					// oversized booking, usually refused
					queue_cmd(brb_pkg::CMD_RESERVE, 8'($urandom),
						brb_pkg::CNT_W'($urandom));
				else
					queue_cmd(3'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST)),
						8'($urandom), brb_pkg::CNT_W'($urandom));
				if (pick < 97)
					queued++;
			end
		end
	endtask

	// everything sent, everything answered, then let the pipe settle
	task automatic wait_for_idle();
		while (commands_to_send.size() != 0 || start || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// only called with the ring idle
	task automatic write_capacity(input logic [brb_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// driver: presents commands at the falling edge, holds one until it transfers,
	// and now and then idles for a random gap
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && cmds_taken != cmds_issued)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (commands_to_send.size() == 0) begin
				start <= 1'b0;
			end else if ($urandom_range(1, 100) <= idle_pct) begin
				gap_left <= $urandom_range(0, 13);
				start    <= 1'b0;
			end else begin
				next_cmd   = commands_to_send.pop_front();
				cmd       <= next_cmd.op;
				data_byte <= next_cmd.din;
				count     <= next_cmd.n_req;
				start     <= 1'b1;
				cmds_issued++;
			end
		end
	end

	// monitor: at the rising edge check the result first, since it belongs to an
	// older command, then fold in a config write or a command transfer
	always @(posedge clk) begin
		if (strobe) begin
			got = {status, read_byte, last, amount, fill_level};
			if (results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result st=%0d byte=%h last=%0d amt=%0d fill=%0d",
						$realtime, got.status, got.rd, got.last, got.amount, got.fill);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: mismatch exp st=%0d byte=%h last=%0d amt=%0d fill=%0d",
							$realtime, want.status, want.rd, want.last, want.amount,
							want.fill);
						$display("    got st=%0d byte=%h last=%0d amt=%0d fill=%0d",
							got.status, got.rd, got.last, got.amount, got.fill);
					end
				end
			end
		end
		if (cfg_we) begin
			// a capacity write empties the ring as well
			capacity_reg = cfg_data;
			empty_ring_model();
		end
		if (start && !busy) begin
			apply_ring_command(cmd, data_byte, count);
			cmds_taken++;
		end
		if (strobe || cfg_we || (start && !busy))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// watchdog
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	// capacity per phase: small rings wrap and refuse often, 0 and 8191 get clamped
	int phase_cap[6]  = '{5, 0, 1, 8191, 33, 4096};
	int phase_len[6]  = '{45, 20, 15, 30, 65, 85};
	int phase_idle[6] = '{25, 40, 10, 30, 20, 0};

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening at the reset capacity
		queue_cmd(brb_pkg::CMD_READ,    8'h00, 13'd5);     // read of an empty ring
		queue_cmd(brb_pkg::CMD_REWIND,  8'h00, 13'd3);     // rewind of an empty ring
		queue_cmd(brb_pkg::CMD_WRITE,   8'h5a, 13'd0);     // byte with no booking
		queue_cmd(brb_pkg::CMD_RESERVE, 8'h00, 13'd0);     // zero-length booking
		queue_cmd(brb_pkg::CMD_WRITE,   8'h11, 13'd0);     // nothing left to write into
		queue_cmd(brb_pkg::CMD_RESERVE, 8'h00, 13'd3);
		queue_cmd(brb_pkg::CMD_WRITE,   8'h00, 13'd0);
		queue_cmd(brb_pkg::CMD_WRITE,   8'hff, 13'd0);
		queue_cmd(brb_pkg::CMD_WRITE,   8'ha5, 13'd0);
		queue_cmd(brb_pkg::CMD_RESERVE, 8'h00, 13'd4);
		queue_cmd(brb_pkg::CMD_WRITE,   8'h3c, 13'd0);
		queue_cmd(brb_pkg::CMD_RESERVE, 8'h00, 13'd2);     // rebooking in mid burst
		queue_cmd(brb_pkg::CMD_WRITE,   8'h81, 13'd0);
		queue_cmd(brb_pkg::CMD_WRITE,   8'h7e, 13'd0);
		queue_cmd(brb_pkg::CMD_READ,    8'h00, 13'd0);     // zero-length read
		queue_cmd(brb_pkg::CMD_READ,    8'h00, 13'd2);
		queue_cmd(brb_pkg::CMD_REWIND,  8'h00, 13'd0);     // zero-length rewind
		queue_cmd(brb_pkg::CMD_REWIND,  8'h00, 13'd1);
		queue_cmd(brb_pkg::CMD_RESERVE, 8'hff, 13'h1fff);  // too big: refused
		queue_cmd(brb_pkg::CMD_WRITE,   8'hc3, 13'h1fff);  // dropped, part of a refused burst
		queue_cmd(brb_pkg::CMD_READ,    8'hff, 13'h1fff);  // long request capped by fill
		queue_cmd(CMD_UNDEF_LAST,       8'hff, 13'h1fff);
		queue_cmd(brb_pkg::CMD_CLEAR,   8'h00, 13'd0);
		// exactly the full store
		queue_cmd(brb_pkg::CMD_RESERVE, 8'h00, brb_pkg::CNT_W'(brb_pkg::STORE_DEPTH));
		queue_cmd(brb_pkg::CMD_WRITE,   8'h96, 13'd0);
		queue_cmd(brb_pkg::CMD_REWIND,  8'h00, 13'h1fff);  // rewind more than is held
		queue_random_traffic(40);
		wait_for_idle();

		for (int p = 0; p < 6; p++) begin
			write_capacity(brb_pkg::CNT_W'(phase_cap[p]));
			idle_pct = phase_idle[p];
			queue_random_traffic(phase_len[p]);
			wait_for_idle();
		end

		if (mismatch_count == 0 && results_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* byte_ring_buffer_with_rewind.f */
sv/brb_pkg.sv
sv/brb_ctrl.sv
sv/brb_dp.sv
sv/byte_ring_buffer_with_rewind.sv
verif/byte_ring_buffer_with_rewind_tb.sv
